// ===== src/slpq_pkg.sv =====
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared types and constants of the sorted-list priority queue.
// ----------------------------------------------------------------------------
package slpq_pkg;

    localparam int DefCapacity = 64;
    localparam int DataW       = 32;
    localparam int ModeW       = 2;
    localparam int StatusW     = 2;
    localparam int CountOutW   = 7;

    typedef logic        [ModeW-1:0]   t_mode;
    typedef logic        [StatusW-1:0] t_status;
    typedef logic signed [DataW-1:0]   t_data;

    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_DELETE = 2'd1;
    localparam t_mode MODE_READ   = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_NONE  = 2'd2;

    // Broadcast from the top level to every cell in the chain.
    typedef struct packed {
        logic              do_ins;
        logic              do_del;
        t_data             value;
        logic [DataW-1:0]  del_pos;
    } t_cell_ctl;

endpackage

// ===== src/sorted_list_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_core
// Sorted priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY signed values in ascending order, one per
// cell. Every cell compares its entry with the incoming value in parallel
// and shifts one step right on insert or one step left on delete, so every
// operation is a single update of the cells: a transfer is taken every cycle
// unless o_stall is high; its result appears in the output register on the
// next cycle. The path through one cell's 32-bit compare and the neighbor
// select sets the clock period. The output register is freed in the same
// cycle its result is taken, so back-pressure on the result side stalls the
// input only while a result is held. No clearing pass is needed after reset.
module sorted_list_priority_queue_core #(
    parameter int CAPACITY = slpq_pkg::DefCapacity
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  slpq_pkg::t_mode                  i_mode,
    input  slpq_pkg::t_data                  i_operand,
    output logic                             o_valid,
    input  logic                             i_stall,
    output slpq_pkg::t_data                  o_min_value,
    output logic                             o_queue_empty,
    output logic [slpq_pkg::CountOutW-1:0]   o_entry_count,
    output slpq_pkg::t_status                o_status
);
    import slpq_pkg::*;

    localparam int CountW = $clog2(CAPACITY + 1);

    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic              r_out_valid;
    t_data             r_min;
    logic              r_empty;
    logic [CountOutW-1:0] r_count_out;
    t_status           r_status;

    t_cell_ctl w_ctl;
    t_status   w_status;
    logic      w_accept;
    logic      w_ins_ok;
    logic      w_del_ok;

    t_data w_entry      [CAPACITY];
    t_data w_entry_next [CAPACITY];
    logic  w_lt         [CAPACITY];

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_ins_ok = (r_count != CountW'(CAPACITY));
    assign w_del_ok = !i_operand[DataW-1]
                      && ({1'b0, i_operand[DataW-2:0]} < DataW'(r_count));

    always_comb begin
        w_ctl.do_ins  = 1'b0;
        w_ctl.do_del  = 1'b0;
        w_ctl.value   = i_operand;
        w_ctl.del_pos = i_operand;
        n_count       = r_count;
        w_status      = STATUS_OK;
        case (i_mode)
            MODE_INSERT: begin
                if (w_ins_ok) begin
                    w_ctl.do_ins = w_accept;
                    n_count      = r_count + CountW'(1);
                end else begin
                    w_status = STATUS_FULL;
                end
            end
            MODE_DELETE: begin
                if (w_del_ok) begin
                    w_ctl.do_del = w_accept;
                    n_count      = r_count - CountW'(1);
                end else begin
                    w_status = STATUS_NONE;
                end
            end
            default: begin
                if (r_count == '0) begin
                    w_status = STATUS_NONE;
                end
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data w_left;
        logic  w_left_lt;
        t_data w_right;

        if (g == 0) begin : g_first
            assign w_left    = i_operand;
            assign w_left_lt = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        slpq_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_valid       (CountW'(g) < r_count),
            .i_left_entry  (w_left),
            .i_left_lt     (w_left_lt),
            .i_right_entry (w_right),
            .o_entry       (w_entry[g]),
            .o_entry_next  (w_entry_next[g]),
            .o_lt          (w_lt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_min       <= (n_count == '0) ? '0 : w_entry_next[0];
            r_empty     <= (n_count == '0);
            r_count_out <= CountOutW'(n_count);
            r_status    <= w_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_min_value   = r_min;
    assign o_queue_empty = r_empty;
    assign o_entry_count = r_count_out;
    assign o_status      = r_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode == MODE_INSERT && w_ins_ok)
        |=> (r_count == $past(r_count) + CountW'(1)))
        else $error("accepted insert did not add an entry");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status == STATUS_FULL) |-> (r_count == CountW'(CAPACITY)))
        else $error("full status with free cells");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CountW'(2)) |-> (w_entry[0] <= w_entry[1]))
        else $error("head of the chain out of order");
`endif

endmodule

// ===== src/slpq_cell.sv =====
// ----------------------------------------------------------------------------
// slpq_cell
// One storage cell of the sorted chain: holds an entry, compares it with
// the value being inserted and trades entries with its neighbors.
// ----------------------------------------------------------------------------
module slpq_cell #(
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  slpq_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_valid,
    input  slpq_pkg::t_data      i_left_entry,
    input  logic                 i_left_lt,
    input  slpq_pkg::t_data      i_right_entry,
    output slpq_pkg::t_data      o_entry,
    output slpq_pkg::t_data      o_entry_next,
    output logic                 o_lt
);
    import slpq_pkg::*;

    t_data r_entry;
    t_data n_entry;
    logic  w_shift_down;

    assign o_lt = i_valid && (r_entry < i_ctl.value);
    assign w_shift_down = (i_ctl.del_pos <= DataW'(INDEX));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_ins && !o_lt) begin
            // The first cell that is not smaller takes the new value; the
            // ones after it take their left neighbor.
            n_entry = i_left_lt ? i_ctl.value : i_left_entry;
        end else if (i_ctl.do_del && w_shift_down) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_entry_next = n_entry;

endmodule
